@@ sv/crsm_pkg.sv @@
// Shared types and constants for the collective rank slot mapper.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package crsm_pkg;

  // Fixed field widths
  localparam int RankW = 10;  // rank_index and slot
  localparam int CntW  = 11;  // rank_count and internal positions
  localparam int StepW = 4;   // round counter, up to CntW rounds

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_RANK_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_KEEP_ORDER = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  // Current configuration as seen by the sequencer
  typedef struct packed {
    logic [CntW-1:0] cnt;   // effective (saturated) rank count
    logic            keep;  // identity mapping
  } cfg_t;

  // Walker state fed into the round unit
  typedef struct packed {
    logic [CntW-1:0]  base;
    logic [CntW-1:0]  off;
    logic [CntW-1:0]  len;
    logic [StepW-1:0] step;
  } walk_t;

  // Outcome of one round
  typedef struct packed {
    logic            skip;  // round not taken, walk ends
    logic            last;  // block length odd, walk ends after this round
    logic [CntW-1:0] base;
    logic [CntW-1:0] off;
    logic [CntW-1:0] len;
  } round_t;

endpackage

`default_nettype wire

@@ sv/crsm_cfg_regs.sv @@
// Configuration registers of the rank slot mapper, with count saturation.
// Depends on crsm_pkg.
`default_nettype none

module crsm_cfg_regs #(
  parameter int MAX_RANKS = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [crsm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [crsm_pkg::CntW-1:0]    cfg_data_i,
  output crsm_pkg::cfg_t                    cfg_o
);
  import crsm_pkg::*;

  localparam int CntMax = (1 << CntW) - 1;
  localparam int SatInt = (MAX_RANKS > CntMax) ? CntMax : MAX_RANKS;
  localparam logic [CntW-1:0] CntSat = CntW'(SatInt);

  logic [CntW-1:0] rank_count_q;
  logic            keep_order_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_count_q <= CntW'(1);
      keep_order_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RANK_COUNT: rank_count_q <= cfg_data_i;
        CFG_KEEP_ORDER: keep_order_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective count clamps at the configured maximum
  always_comb begin
    cfg_o.cnt  = (rank_count_q > CntSat) ? CntSat : rank_count_q;
    cfg_o.keep = keep_order_q;
  end

endmodule

`default_nettype wire

@@ sv/crsm_round.sv @@
// One reordering round: the shared step unit used once per cycle by the walker.
// Depends on crsm_pkg.
`default_nettype none

module crsm_round (
  input  wire logic [crsm_pkg::CntW-1:0] cnt_m1_i,
  input  wire crsm_pkg::walk_t           cur_i,
  output crsm_pkg::round_t               nxt_o
);
  import crsm_pkg::*;

  logic [CntW:0]   sum_w;
  logic [CntW:0]   blk_sum;
  logic [CntW:0]   blocks;
  logic [CntW-1:0] off_r;
  logic [CntW-1:0] half;
  logic            no_rounds;

  always_comb begin
    // Round is skipped once no bits of count-1 remain or at most one block
    no_rounds = (cnt_m1_i >> cur_i.step) == '0;
    blk_sum   = {1'b0, cnt_m1_i} + ((CntW+1)'(1) << cur_i.step);
    blocks    = blk_sum >> (cur_i.step + StepW'(1));
    nxt_o.skip = no_rounds || (blocks <= (CntW+1)'(1));

    // Even offset halves; odd offset goes to (off+len)/2
    sum_w = {1'b0, cur_i.off} + {1'b0, cur_i.len};
    off_r = cur_i.off[0] ? sum_w[CntW:1] : (cur_i.off >> 1);

    // Next block length; the new offset falls in the lower or upper half-block
    half       = cur_i.len >> 1;
    nxt_o.last = cur_i.len[0];
    nxt_o.len  = half;
    if (!cur_i.len[0] && (off_r >= half)) begin
      nxt_o.base = cur_i.base + half;
      nxt_o.off  = off_r - half;
    end else begin
      nxt_o.base = cur_i.base;
      nxt_o.off  = off_r;
    end
  end

endmodule

`default_nettype wire

@@ sv/collective_rank_slot_mapper.sv @@
// Rank slot mapper: one query in, one slot out, walked one round per cycle.
// Sequence: accept in idle, then walk (one round per cycle of the shared round unit, at most
// nine rounds at 1024 ranks, until a round is skipped or taken as last), then flush loads the
// output register once it is free. Invalid ranks and identity mode skip the walk.
// One query at a time; the next is taken once the result is loaded.
// Reset (async, active low): idle, no result, rank_count 1, keep_order 0.
`default_nettype none

module collective_rank_slot_mapper #(
  parameter int MAX_RANKS = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [crsm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [crsm_pkg::CntW-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [crsm_pkg::RankW-1:0]   rank_index_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [crsm_pkg::RankW-1:0]        slot_o,
  output logic                              index_ok_o
);
  import crsm_pkg::*;

  cfg_t   cfg;
  walk_t  cur;
  round_t nxt;

  state_e state_q, state_d;
  logic [CntW-1:0]  base_q, base_d;
  logic [CntW-1:0]  off_q, off_d;
  logic [CntW-1:0]  len_q, len_d;
  logic [StepW-1:0] step_q, step_d;
  logic             ok_q, ok_d;
  logic             out_valid_q, out_valid_d;
  logic [RankW-1:0] slot_q, slot_d;
  logic             index_ok_q, index_ok_d;

  logic            in_beat;
  logic            out_free;
  logic            rank_ok;
  logic [CntW-1:0] rank_ext;
  logic [CntW-1:0] final_pos;

  crsm_cfg_regs #(
    .MAX_RANKS (MAX_RANKS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  always_comb begin
    cur.base = base_q;
    cur.off  = off_q;
    cur.len  = len_q;
    cur.step = step_q;
  end

  crsm_round u_round (
    .cnt_m1_i (cfg.cnt - CntW'(1)),
    .cur_i    (cur),
    .nxt_o    (nxt)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign rank_ext   = CntW'(rank_index_i);
  assign rank_ok    = rank_ext < cfg.cnt;
  assign final_pos  = base_q + off_q;

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walker and output payload
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    off_q      <= off_d;
    len_q      <= len_d;
    step_q     <= step_d;
    ok_q       <= ok_d;
    slot_q     <= slot_d;
    index_ok_q <= index_ok_d;
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    off_d       = off_q;
    len_d       = len_q;
    step_d      = step_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q && !out_ready_i;
    slot_d      = slot_q;
    index_ok_d  = index_ok_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          base_d = '0;
          len_d  = cfg.cnt;
          step_d = '0;
          ok_d   = rank_ok;
          off_d  = rank_ok ? rank_ext : '0;
          // identity mode and invalid ranks need no rounds
          state_d = (rank_ok && !cfg.keep) ? ST_WALK : ST_FLUSH;
        end
      end
      ST_WALK: begin
        if (nxt.skip) begin
          state_d = ST_FLUSH;
        end else begin
          base_d = nxt.base;
          off_d  = nxt.off;
          len_d  = nxt.len;
          step_d = step_q + StepW'(1);
          if (nxt.last) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          slot_d      = final_pos[RankW-1:0];
          index_ok_d  = ok_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign index_ok_o  = index_ok_q;

endmodule

`default_nettype wire

@@ sv/crsm_checker.sv @@
// Port-level checks for the rank slot mapper, bound to the top level.
// Depends on crsm_pkg and collective_rank_slot_mapper.
`default_nettype none

module crsm_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [crsm_pkg::RankW-1:0] slot_o,
  input wire logic                       index_ok_o
);
  import crsm_pkg::*;

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_o) && $stable(index_ok_o))
    else $error("result changed while stalled");

  // An invalid rank always reports slot zero
  a_bad_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !index_ok_o |-> slot_o == '0)
    else $error("invalid rank with nonzero slot");

  // One query at a time: busy right after an input beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // No result can appear in the cycle right after a query is taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (!out_valid_o || out_ready_i) |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind collective_rank_slot_mapper crsm_checker u_crsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .slot_o      (slot_o),
  .index_ok_o  (index_ok_o)
);

`default_nettype wire
